FILE: rtl/toroidal_four_neighbour_mask_assert.svh
// Assertion macros for the four-neighbour mask block.
// Used by the top level only; needs nothing else.
`ifndef TOROIDAL_FOUR_NEIGHBOUR_MASK_ASSERT_SVH
`define TOROIDAL_FOUR_NEIGHBOUR_MASK_ASSERT_SVH

// condition holds at every clock edge out of reset
`define TFNM_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define TFNM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tfnm_pkg.sv
// Shared types and constants of the four-neighbour mask block.
// No dependencies.
package tfnm_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int COORD_W = 8;
    localparam int SIZE_W  = 9;
    localparam int CODE_W  = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // alpha bit that marks a pixel occupied
    localparam int OCC_BIT_POS = 7;

    // cell code bit positions
    localparam int CODE_LEFT_BIT  = 0;
    localparam int CODE_UP_BIT    = 1;
    localparam int CODE_RIGHT_BIT = 2;
    localparam int CODE_DOWN_BIT  = 3;
    localparam int CODE_SELF_BIT  = 4;

    // item actions
    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    // map size in use, already clamped
    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } t_size;

endpackage

FILE: rtl/tfnm_if.sv
// Valid/ready channel interfaces: input items and result items.
// Depends on tfnm_pkg.
interface tfnm_in_if import tfnm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] alpha;

    modport source (output valid, action, column, row, alpha, input ready);
    modport sink   (input valid, action, column, row, alpha, output ready);
endinterface

interface tfnm_out_if import tfnm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] cell_code;
    logic              out_of_range;

    modport source (output valid, cell_code, out_of_range, input ready);
    modport sink   (input valid, cell_code, out_of_range, output ready);
endinterface

FILE: rtl/toroidal_four_neighbour_mask.sv
// Toroidal four-neighbour occupancy mask, top level.
// Depends on tfnm_pkg, tfnm_if, tfnm_cfg, tfnm_map_mem and the assert header.
//
// Usage:
//  i_item carries load and query items (valid/ready). A load stores bit 7
//  of alpha at (column, row) of the occupancy map; it gives no result.
//  A query returns one result on o_result: a 5-bit cell code (self,
//  left, up, right, down, wrapping round the size in use) and an
//  out-of-range flag.
//  Map width and height are written over APB at byte 0 and 4; write them
//  only while no item is in flight.
//  A load is written to the map as it is accepted. An out-of-range query
//  finishes in S_IDLE and one on an empty cell in S_SELF; an occupied cell
//  goes on through S_UP and S_DOWN, for the three row reads (own row,
//  row above, row below) on the single map read port.
//  Results sit in an output register; while it waits for the receiver the
//  block still accepts loads and starts the next query, parking a finished
//  query until the register frees up; no item is taken while one is parked.
//  Reset clears the control state and sets both sizes to 256. The map
//  itself is not cleared and must be loaded before queries mean anything.
`include "toroidal_four_neighbour_mask_assert.svh"

module toroidal_four_neighbour_mask import tfnm_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tfnm_in_if.sink           i_item,
    tfnm_out_if.source        o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int COL_IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_IW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_XW = (COL_IW > COORD_W) ? COL_IW : COORD_W;
    localparam int ROW_XW = (ROW_IW > COORD_W) ? ROW_IW : COORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SELF,
        S_UP,
        S_DOWN,
        S_HOLD
    } t_state;

    function automatic logic [COL_IW-1:0] col_idx(input logic [COORD_W-1:0] v);
        logic [COL_XW-1:0] ext;
        ext = COL_XW'(v);
        return ext[COL_IW-1:0];
    endfunction

    function automatic logic [ROW_IW-1:0] row_idx(input logic [COORD_W-1:0] v);
        logic [ROW_XW-1:0] ext;
        ext = ROW_XW'(v);
        return ext[ROW_IW-1:0];
    endfunction

    t_size                size;
    logic [MAX_WIDTH-1:0] mem_rd_data;
    logic                 mem_wr_en;
    logic                 mem_rd_en;
    logic [ROW_IW-1:0]    mem_rd_row;

    t_state               r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    logic [CODE_W-1:0]    r_out_code, n_out_code;
    logic                 r_out_oor, n_out_oor;
    logic [CODE_W-1:0]    r_res_code, n_res_code;
    logic                 r_res_oor, n_res_oor;
    logic [CODE_W-1:0]    r_code, n_code;
    logic [COORD_W-1:0]   r_x, n_x;
    logic [COORD_W-1:0]   r_xl, n_xl;
    logic [COORD_W-1:0]   r_xr, n_xr;
    logic [COORD_W-1:0]   r_yu, n_yu;
    logic [COORD_W-1:0]   r_yd, n_yd;

    logic                 slot_free;
    logic                 fin;
    logic [CODE_W-1:0]    fin_code;
    logic                 fin_oor;
    logic                 load_in_store;
    logic                 q_oor;
    logic                 self_bit;

    tfnm_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_size  (size)
    );

    tfnm_map_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_IW     (COL_IW),
        .ROW_IW     (ROW_IW)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_row  (row_idx(i_item.row)),
        .i_wr_col  (col_idx(i_item.column)),
        .i_wr_bit  (i_item.alpha[OCC_BIT_POS]),
        .i_rd_en   (mem_rd_en),
        .i_rd_row  (mem_rd_row),
        .o_rd_data (mem_rd_data)
    );

    // one item at a time; loads and queries never share a memory cycle
    assign i_item.ready = (r_state == S_IDLE);

    assign o_result.valid        = r_out_valid;
    assign o_result.cell_code    = r_out_code;
    assign o_result.out_of_range = r_out_oor;

    assign slot_free     = !r_out_valid || o_result.ready;
    assign load_in_store = (32'(i_item.column) < 32'(MAX_WIDTH))
                        && (32'(i_item.row) < 32'(MAX_HEIGHT));
    assign q_oor         = ({1'b0, i_item.column} >= size.width)
                        || ({1'b0, i_item.row} >= size.height);
    assign self_bit      = mem_rd_data[col_idx(r_x)];

    // next-state and memory control
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_code  = r_out_code;
        n_out_oor   = r_out_oor;
        n_res_code  = r_res_code;
        n_res_oor   = r_res_oor;
        n_code      = r_code;
        n_x         = r_x;
        n_xl        = r_xl;
        n_xr        = r_xr;
        n_yu        = r_yu;
        n_yd        = r_yd;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_row  = row_idx(i_item.row);
        fin         = 1'b0;
        fin_code    = '0;
        fin_oor     = 1'b0;

        // result taken by the receiver
        if (o_result.ready)
            n_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    if (i_item.action == ACTION_LOAD) begin
                        mem_wr_en = load_in_store;
                    end else if (q_oor) begin
                        fin     = 1'b1;
                        fin_oor = 1'b1;
                    end else begin
                        // own row first; neighbour coordinates wrap
                        mem_rd_en = 1'b1;
                        n_x  = i_item.column;
                        n_xl = (i_item.column == '0) ? COORD_W'(size.width - SIZE_W'(1))
                                                     : i_item.column - COORD_W'(1);
                        n_xr = ({1'b0, i_item.column} == size.width - SIZE_W'(1))
                             ? '0 : i_item.column + COORD_W'(1);
                        n_yu = (i_item.row == '0) ? COORD_W'(size.height - SIZE_W'(1))
                                                  : i_item.row - COORD_W'(1);
                        n_yd = ({1'b0, i_item.row} == size.height - SIZE_W'(1))
                             ? '0 : i_item.row + COORD_W'(1);
                        n_state = S_SELF;
                    end
                end
            end
            S_SELF: begin
                if (!self_bit) begin
                    fin = 1'b1;
                end else begin
                    n_code                 = '0;
                    n_code[CODE_SELF_BIT]  = 1'b1;
                    n_code[CODE_LEFT_BIT]  = mem_rd_data[col_idx(r_xl)];
                    n_code[CODE_RIGHT_BIT] = mem_rd_data[col_idx(r_xr)];
                    mem_rd_en  = 1'b1;
                    mem_rd_row = row_idx(r_yu);
                    n_state    = S_UP;
                end
            end
            S_UP: begin
                n_code[CODE_UP_BIT] = self_bit;
                mem_rd_en  = 1'b1;
                mem_rd_row = row_idx(r_yd);
                n_state    = S_DOWN;
            end
            S_DOWN: begin
                fin                     = 1'b1;
                fin_code                = r_code;
                fin_code[CODE_DOWN_BIT] = self_bit;
            end
            S_HOLD: begin
                fin      = 1'b1;
                fin_code = r_res_code;
                fin_oor  = r_res_oor;
            end
            default: n_state = S_IDLE;
        endcase

        // hand the result to the output register, or park it
        if (fin) begin
            if (slot_free) begin
                n_out_valid = 1'b1;
                n_out_code  = fin_code;
                n_out_oor   = fin_oor;
                n_state     = S_IDLE;
            end else begin
                n_res_code = fin_code;
                n_res_oor  = fin_oor;
                n_state    = S_HOLD;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_out_code <= n_out_code;
        r_out_oor  <= n_out_oor;
        r_res_code <= n_res_code;
        r_res_oor  <= n_res_oor;
        r_code     <= n_code;
        r_x        <= n_x;
        r_xl       <= n_xl;
        r_xr       <= n_xr;
        r_yu       <= n_yu;
        r_yd       <= n_yd;
    end

    // checks
    `TFNM_ASSERT_HOLDS(a_mem_port_excl, i_clk, i_rst_n, !(mem_wr_en && mem_rd_en), "map written and read in one cycle")
    `TFNM_ASSERT_IMPLIES(a_oor_code_zero, i_clk, i_rst_n, r_out_valid && r_out_oor, r_out_code == '0, "out-of-range result with non-zero code")
    `TFNM_ASSERT_IMPLIES(a_hold_when_full, i_clk, i_rst_n, r_state == S_HOLD, r_out_valid, "result parked while output register empty")

endmodule

FILE: rtl/tfnm_cfg.sv
// APB register file for map width and height, with size clamping.
// Depends on tfnm_pkg.
module tfnm_cfg import tfnm_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_size             o_size
);

    localparam int W_LIM = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int H_LIM = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    logic [SIZE_W-1:0] r_map_width;
    logic [SIZE_W-1:0] r_map_height;
    logic              wr_xfer;

    assign pready  = 1'b1;
    assign wr_xfer = psel & penable & pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= SIZE_W'(256);
            r_map_height <= SIZE_W'(256);
        end else if (wr_xfer) begin
            unique case (paddr[2])
                REG_MAP_WIDTH:  r_map_width  <= pwdata[SIZE_W-1:0];
                REG_MAP_HEIGHT: r_map_height <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            REG_MAP_WIDTH:  prdata = APB_DW'(r_map_width);
            REG_MAP_HEIGHT: prdata = APB_DW'(r_map_height);
            default:        prdata = '0;
        endcase
    end

    // clamp to [1, min(max, 256)]
    always_comb begin
        if (r_map_width == '0)
            o_size.width = SIZE_W'(1);
        else if (r_map_width > SIZE_W'(W_LIM))
            o_size.width = SIZE_W'(W_LIM);
        else
            o_size.width = r_map_width;

        if (r_map_height == '0)
            o_size.height = SIZE_W'(1);
        else if (r_map_height > SIZE_W'(H_LIM))
            o_size.height = SIZE_W'(H_LIM);
        else
            o_size.height = r_map_height;
    end

endmodule

FILE: rtl/tfnm_map_mem.sv
// Occupancy map: one row of the image per word, bit-write port and
// registered row read port. Depends on tfnm_pkg.
module tfnm_map_mem import tfnm_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COL_IW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int ROW_IW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ROW_IW-1:0]    i_wr_row,
    input  logic [COL_IW-1:0]    i_wr_col,
    input  logic                 i_wr_bit,
    input  logic                 i_rd_en,
    input  logic [ROW_IW-1:0]    i_rd_row,
    output logic [MAX_WIDTH-1:0] o_rd_data
);

    logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] r_rd_data;

    // single-bit write
    always_ff @(posedge i_clk) begin
        if (i_wr_en)
            mem[i_wr_row][i_wr_col] <= i_wr_bit;
    end

    // whole-row read, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en)
            r_rd_data <= mem[i_rd_row];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the toroidal four-neighbour occupancy mask.
// Needs tfnm_pkg, the tfnm_in_if/tfnm_out_if interfaces and the block itself.
`timescale 1ns / 1ps

module testbench;
    import tfnm_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;
    localparam int RANDOM_ITEMS = 750;

    localparam logic [APB_AW-1:0] ADDR_MAP_WIDTH  = {REG_MAP_WIDTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_MAP_HEIGHT = {REG_MAP_HEIGHT, 2'b00};

    // Occupancy map mirror, size registers and the queue of expected cell codes
    class occupancy_scoreboard;
        typedef struct packed {
            logic [CODE_W-1:0] code;
            logic              oor;
        } t_cell_result;

        bit                occ [0:65535];
        logic [SIZE_W-1:0] width_reg;
        logic [SIZE_W-1:0] height_reg;
        t_cell_result      expected_codes [$];
        int                errors;
        int                checked;

        function new();
            width_reg  = 256;
            height_reg = 256;
            errors     = 0;
            checked    = 0;
        endfunction

        static function int unsigned clamp_size(logic [SIZE_W-1:0] v);
            if (v == 0) return 1;
            if (v > 256) return 256;
            return v;
        endfunction

        function int unsigned cols_in_use();
            return clamp_size(width_reg);
        endfunction

        function int unsigned rows_in_use();
            return clamp_size(height_reg);
        endfunction

        function void write_reg(logic idx, logic [SIZE_W-1:0] v);
            if (idx == REG_MAP_WIDTH)
                width_reg = v;
            else
                height_reg = v;
        endfunction

        function bit cell_at(int unsigned x, int unsigned y);
            return occ[y * 256 + x];
        endfunction

        // accepted input: loads update the mirror, queries queue a cell code
        function void note_item(logic act, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                                logic [COORD_W-1:0] alpha);
            int unsigned  w, h, xl, xr, yu, yd;
            t_cell_result r;
            if (act == ACTION_LOAD) begin
                occ[{row, col}] = alpha[OCC_BIT_POS];
                return;
            end
            w = cols_in_use();
            h = rows_in_use();
            r = '0;
            if (col >= w || row >= h) begin
                r.oor = 1'b1;
            end else if (cell_at(col, row)) begin
                xl = (col == 0) ? w - 1 : col - 1;
                xr = (col == w - 1) ? 0 : col + 1;
                yu = (row == 0) ? h - 1 : row - 1;
                yd = (row == h - 1) ? 0 : row + 1;
                r.code[CODE_SELF_BIT]  = 1'b1;
                r.code[CODE_LEFT_BIT]  = cell_at(xl, row);
                r.code[CODE_UP_BIT]    = cell_at(col, yu);
                r.code[CODE_RIGHT_BIT] = cell_at(xr, row);
                r.code[CODE_DOWN_BIT]  = cell_at(col, yd);
            end
            expected_codes.insert(expected_codes.size(), r);
        endfunction

        function void check_result(logic [CODE_W-1:0] code, logic oor);
            t_cell_result r;
            if (expected_codes.size() == 0) begin
                $error("unexpected result: cell_code %0h out_of_range %0b", code, oor);
                errors++;
                return;
            end
            r = expected_codes.pop_front();
            checked++;
            if (code !== r.code) begin
                $error("cell_code mismatch: expected %0h actual %0h", r.code, code);
                errors++;
            end
            if (oor !== r.oor) begin
                $error("out_of_range mismatch: expected %0b actual %0b", r.oor, oor);
                errors++;
            end
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    tfnm_in_if  item_if ();
    tfnm_out_if result_if ();

    toroidal_four_neighbour_mask dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    occupancy_scoreboard sb = new();

    // cells written so far; queries never touch anything outside this set
    bit cell_loaded [0:65535];
    bit idle_on;
    bit hold_request;
    int n_items;
    int n_loads;
    int n_queries;
    int n_oor;
    int n_phases;

    // clock, 2 ns period
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // one input transfer, noted in the scoreboard at acceptance
    task automatic send_item(logic act, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                             logic [COORD_W-1:0] alpha);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            item_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        item_if.valid  <= 1'b1;
        item_if.action <= act;
        item_if.column <= col;
        item_if.row    <= row;
        item_if.alpha  <= alpha;
        do @(posedge i_clk); while (!item_if.ready);
        sb.note_item(act, col, row, alpha);
        n_items++;
        if (act == ACTION_LOAD) begin
            n_loads++;
            cell_loaded[{row, col}] = 1'b1;
        end else begin
            n_queries++;
        end
    endtask

    task automatic end_items();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // size change; the upper data bits carry noise the block must ignore
    task automatic set_map_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        logic [APB_DW-1:0] data;
        end_items();
        wait_drained();
        data = $urandom();
        data[SIZE_W-1:0] = w;
        apb_write(ADDR_MAP_WIDTH, data);
        sb.write_reg(REG_MAP_WIDTH, w);
        data = $urandom();
        data[SIZE_W-1:0] = h;
        apb_write(ADDR_MAP_HEIGHT, data);
        sb.write_reg(REG_MAP_HEIGHT, h);
        n_phases++;
    endtask

    // fill every unwritten cell in use, refresh about half of the rest
    task automatic load_area();
        int unsigned w, h;
        w = sb.cols_in_use();
        h = sb.rows_in_use();
        for (int unsigned y = 0; y < h; y++)
            for (int unsigned x = 0; x < w; x++)
                if (!cell_loaded[y * 256 + x] || $urandom_range(0, 1) == 1)
                    send_item(ACTION_LOAD, x[7:0], y[7:0], 8'($urandom()));
    endtask

    // query beyond the size in use, else an ordinary one if no such cell exists
    task automatic send_oor_query();
        int unsigned w, h;
        w = sb.cols_in_use();
        h = sb.rows_in_use();
        if (w < 256 && (h == 256 || $urandom_range(0, 1) == 1)) begin
            n_oor++;
            send_item(ACTION_QUERY, 8'($urandom_range(w, 255)), 8'($urandom()), 8'($urandom()));
        end else if (h < 256) begin
            n_oor++;
            send_item(ACTION_QUERY, 8'($urandom()), 8'($urandom_range(h, 255)), 8'($urandom()));
        end else begin
            send_item(ACTION_QUERY, 8'($urandom()), 8'($urandom()), 8'($urandom()));
        end
    endtask

    // mixed traffic once the whole area in use is loaded
    task automatic mixed_items(int count);
        int unsigned w, h;
        int          r;
        w = sb.cols_in_use();
        h = sb.rows_in_use();
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(ACTION_QUERY, 8'($urandom_range(0, w - 1)),
                          8'($urandom_range(0, h - 1)), 8'($urandom()));
            else if (r < 60)
                send_oor_query();
            else if (r < 90)
                send_item(ACTION_LOAD, 8'($urandom_range(0, w - 1)),
                          8'($urandom_range(0, h - 1)), 8'($urandom()));
            else
                send_item(ACTION_LOAD, 8'($urandom()), 8'($urandom()), 8'($urandom()));
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left       = 0;
        result_if.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (stall_left > 0) begin
                result_if.ready <= 1'b0;
                stall_left--;
            end else begin
                result_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // result check at every accepted result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready)
            sb.check_result(result_if.cell_code, result_if.out_of_range);
    end

    initial begin
        #2_000_000;
        $display("FAIL toroidal_four_neighbour_mask");
        $finish;
    end

    // stimulus
    initial begin
        int random_start;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        item_if.valid  = 1'b0;
        item_if.action = ACTION_LOAD;
        item_if.column = '0;
        item_if.row    = '0;
        item_if.alpha  = '0;
        idle_on        = 1'b1;
        hold_request   = 1'b0;
        n_items        = 0;
        n_loads        = 0;
        n_queries      = 0;
        n_oor          = 0;
        n_phases       = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full 256 x 256 size from reset: wrap at both ends of each axis
        send_item(ACTION_LOAD, 8'd0, 8'd0, 8'h80);
        send_item(ACTION_LOAD, 8'd255, 8'd0, 8'hFF);
        send_item(ACTION_LOAD, 8'd1, 8'd0, 8'h7F);
        send_item(ACTION_LOAD, 8'd0, 8'd255, 8'h80);
        send_item(ACTION_LOAD, 8'd0, 8'd1, 8'h00);
        send_item(ACTION_QUERY, 8'd0, 8'd0, 8'h00);
        send_item(ACTION_LOAD, 8'd255, 8'd255, 8'hC0);
        send_item(ACTION_LOAD, 8'd254, 8'd255, 8'h80);
        send_item(ACTION_LOAD, 8'd255, 8'd254, 8'h01);
        send_item(ACTION_QUERY, 8'd255, 8'd255, 8'hFF);
        send_item(ACTION_QUERY, 8'd1, 8'd0, 8'h00);
        send_item(ACTION_QUERY, 8'd0, 8'd1, 8'h00);

        // zero size clamps to a single cell that is its own neighbour
        set_map_size(9'd0, 9'd0);
        send_item(ACTION_QUERY, 8'd0, 8'd0, 8'h00);
        send_item(ACTION_QUERY, 8'd1, 8'd0, 8'h00);
        send_item(ACTION_QUERY, 8'd0, 8'd1, 8'h00);
        send_item(ACTION_QUERY, 8'd255, 8'd255, 8'h00);
        send_item(ACTION_LOAD, 8'd0, 8'd0, 8'h00);
        send_item(ACTION_QUERY, 8'd0, 8'd0, 8'h00);
        n_oor += 3;

        // oversized registers clamp to the full store, one axis at a time
        random_start = n_items;
        set_map_size(9'h1FF, 9'd1);
        load_area();
        mixed_items(40);
        set_map_size(9'd1, 9'd300);
        load_area();
        mixed_items(40);

        // small random sizes
        while (n_items - random_start < RANDOM_ITEMS) begin
            set_map_size($urandom_range(0, 3) == 0 ? 9'd0 : 9'($urandom_range(1, 12)),
                         9'($urandom_range(1, 12)));
            idle_on = ($urandom_range(0, 3) != 0);
            load_area();
            if (n_phases == 4) begin
                // receiver holds off while queries keep coming
                hold_request = 1'b1;
                repeat (40)
                    send_item(ACTION_QUERY, 8'($urandom_range(0, sb.cols_in_use() - 1)),
                              8'($urandom_range(0, sb.rows_in_use() - 1)), 8'($urandom()));
            end
            mixed_items(30);
            if (n_phases == 4) begin
                // sender pauses until every result is back
                end_items();
                wait_drained();
            end
            mixed_items(30);
        end

        end_items();
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d transfers in %0d size settings: %0d loads, %0d queries",
                 n_items, n_phases, n_loads, n_queries);
        $display("(%0d beyond the size in use), %0d results checked, %0d errors",
                 n_oor, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS toroidal_four_neighbour_mask");
        else
            $display("FAIL toroidal_four_neighbour_mask");
        $finish;
    end

endmodule
